>>> rtl/cvma_pkg.sv
// Shared types and constants for the conjugated vector-matrix accumulator.
package cvma_pkg;

    localparam int COL_W          = 8;
    localparam int OP_W           = 16;
    localparam int MUL_W          = 2 * OP_W;
    localparam int PROD_W         = MUL_W + 1;
    localparam int ACC_W          = 40;
    localparam int DEF_MAX_COLS   = 256;
    localparam int S_TDATA_W      = 152;
    localparam int M_TDATA_W      = 88;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_PRELOAD = 2'd0,
        ACT_ACCUM   = 2'd1,
        ACT_READ    = 2'd2
    } t_action;

    typedef struct packed {
        t_action          action;
        logic [COL_W-1:0] column;
        logic             in_range;
    } t_stage_ctrl;

endpackage

>>> rtl/cvma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cvma_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cvma_cmul.sv
// Registered partial products of a times conj(v), summed into real and imaginary parts.
module cvma_cmul
    import cvma_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [OP_W-1:0]   i_a_re,
    input  logic signed [OP_W-1:0]   i_a_im,
    input  logic signed [OP_W-1:0]   i_v_re,
    input  logic signed [OP_W-1:0]   i_v_im,
    output logic signed [PROD_W-1:0] o_prod_re,
    output logic signed [PROD_W-1:0] o_prod_im
);

    logic signed [MUL_W-1:0] r_rr, r_ii, r_ir, r_ri;
    logic signed [MUL_W-1:0] n_rr, n_ii, n_ir, n_ri;

    assign n_rr = i_a_re * i_v_re;
    assign n_ii = i_a_im * i_v_im;
    assign n_ir = i_a_im * i_v_re;
    assign n_ri = i_a_re * i_v_im;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rr <= n_rr;
            r_ii <= n_ii;
            r_ir <= n_ir;
            r_ri <= n_ri;
        end
    end

    assign o_prod_re = $signed({r_rr[MUL_W-1], r_rr}) + $signed({r_ii[MUL_W-1], r_ii});
    assign o_prod_im = $signed({r_ir[MUL_W-1], r_ir}) - $signed({r_ri[MUL_W-1], r_ri});

endmodule

>>> rtl/conj_vector_matrix_accumulate.sv
// Top level: column accumulators of v^H A held in one RAM, read-modify-write pipeline.
// Stages in order: multiply, read and update, output register.
// Throughput: one beat per cycle while the output is not stalled; a same-column beat right behind another
// is served by a forwarding register on the last write, so the RAM read-modify-write sets no extra stall.
// Output stall holds the pipeline; up to two beats are taken in while a result waits.
// Reset (synchronous, active low) clears the stage valids and the forwarding valid;
// the accumulator RAM is not cleared; a column must be read only after a preload, and the block does not enforce this.
module conj_vector_matrix_accumulate
    import cvma_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // column, a_re, a_im, v_re, v_im, load_re, load_im
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // action
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_column, sum_re, sum_im
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // saturated
    output logic                 m_axis_tuser
);

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int XW = AW + COL_W;

    logic [COL_W-1:0]        in_column;
    logic signed [OP_W-1:0]  in_a_re, in_a_im, in_v_re, in_v_im;
    logic signed [ACC_W-1:0] in_load_re, in_load_im;
    logic [XW-1:0]           col_ext;
    t_stage_ctrl             in_ctrl;
    logic                    accept, adv1, adv2;

    assign in_column  = s_axis_tdata[7:0];
    assign in_a_re    = s_axis_tdata[23:8];
    assign in_a_im    = s_axis_tdata[39:24];
    assign in_v_re    = s_axis_tdata[55:40];
    assign in_v_im    = s_axis_tdata[71:56];
    assign in_load_re = s_axis_tdata[111:72];
    assign in_load_im = s_axis_tdata[151:112];

    assign col_ext          = {{AW{1'b0}}, in_column};
    assign in_ctrl.action   = t_action'(s_axis_tuser);
    assign in_ctrl.column   = in_column;
    assign in_ctrl.in_range = (col_ext < XW'(MAX_COLS));

    logic                    r1_valid, r2_valid, r_out_valid, r_wr_valid;
    t_stage_ctrl             r1_ctrl, r2_ctrl;
    logic [AW-1:0]           r1_addr, r2_addr, r_wr_addr;
    logic signed [ACC_W-1:0] r1_load_re, r1_load_im, r2_load_re, r2_load_im;
    logic signed [PROD_W-1:0] r2_prod_re, r2_prod_im;
    logic signed [ACC_W-1:0] r_wr_re, r_wr_im;
    logic [COL_W-1:0]        r_out_column;
    logic signed [ACC_W-1:0] r_out_re, r_out_im;
    logic                    r_out_sat;

    logic signed [PROD_W-1:0] prod_re, prod_im;
    logic [2*ACC_W-1:0]       ram_rdata;
    logic                     fwd_hit, wr_req, wr_en;
    logic signed [ACC_W-1:0]  acc_re, acc_im, n_res_re, n_res_im, sat_re, sat_im;
    logic signed [ACC_W:0]    sum_re, sum_im;
    logic                     clip_re, clip_im, n_sat;

    assign adv2          = !r_out_valid || m_axis_tready;
    assign adv1          = r1_valid && (!r2_valid || adv2);
    assign s_axis_tready = !r1_valid || adv1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cvma_cmul u_cmul (
        .i_clk     (i_clk),
        .i_en      (accept),
        .i_a_re    (in_a_re),
        .i_a_im    (in_a_im),
        .i_v_re    (in_v_re),
        .i_v_im    (in_v_im),
        .o_prod_re (prod_re),
        .o_prod_im (prod_im)
    );

    cvma_ram #(
        .WIDTH (2 * ACC_W),
        .DEPTH (MAX_COLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r2_addr),
        .i_wdata ({n_res_im, n_res_re}),
        .i_re    (adv1),
        .i_raddr (r1_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_wr_valid  <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r1_valid <= s_axis_tvalid;
            end
            if (!r2_valid || adv2) begin
                r2_valid <= adv1;
            end
            if (adv2) begin
                r_out_valid <= r2_valid;
            end
            if (wr_en) begin
                r_wr_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_ctrl    <= in_ctrl;
            r1_addr    <= col_ext[AW-1:0];
            r1_load_re <= in_load_re;
            r1_load_im <= in_load_im;
        end
        if (adv1) begin
            r2_ctrl    <= r1_ctrl;
            r2_addr    <= r1_addr;
            r2_load_re <= r1_load_re;
            r2_load_im <= r1_load_im;
            r2_prod_re <= prod_re;
            r2_prod_im <= prod_im;
        end
        if (wr_en) begin
            r_wr_addr <= r2_addr;
            r_wr_re   <= n_res_re;
            r_wr_im   <= n_res_im;
        end
        if (adv2 && r2_valid) begin
            r_out_column <= r2_ctrl.column;
            r_out_re     <= n_res_re;
            r_out_im     <= n_res_im;
            r_out_sat    <= n_sat;
        end
    end

    assign fwd_hit = r_wr_valid && (r_wr_addr == r2_addr);
    assign acc_re  = fwd_hit ? r_wr_re : ram_rdata[ACC_W-1:0];
    assign acc_im  = fwd_hit ? r_wr_im : ram_rdata[2*ACC_W-1:ACC_W];

    assign sum_re  = {acc_re[ACC_W-1], acc_re}
                   + {{(ACC_W+1-PROD_W){r2_prod_re[PROD_W-1]}}, r2_prod_re};
    assign sum_im  = {acc_im[ACC_W-1], acc_im}
                   + {{(ACC_W+1-PROD_W){r2_prod_im[PROD_W-1]}}, r2_prod_im};
    assign clip_re = sum_re[ACC_W] != sum_re[ACC_W-1];
    assign clip_im = sum_im[ACC_W] != sum_im[ACC_W-1];
    assign sat_re  = clip_re ? (sum_re[ACC_W] ? ACC_MIN : ACC_MAX) : sum_re[ACC_W-1:0];
    assign sat_im  = clip_im ? (sum_im[ACC_W] ? ACC_MIN : ACC_MAX) : sum_im[ACC_W-1:0];

    always_comb begin
        n_res_re = '0;
        n_res_im = '0;
        n_sat    = 1'b0;
        wr_req   = 1'b0;
        if (r2_ctrl.in_range) begin
            case (r2_ctrl.action)
                ACT_PRELOAD: begin
                    n_res_re = r2_load_re;
                    n_res_im = r2_load_im;
                    wr_req   = 1'b1;
                end
                ACT_ACCUM: begin
                    n_res_re = sat_re;
                    n_res_im = sat_im;
                    n_sat    = clip_re || clip_im;
                    wr_req   = 1'b1;
                end
                default: begin
                    n_res_re = acc_re;
                    n_res_im = acc_im;
                end
            endcase
        end
    end

    assign wr_en = r2_valid && adv2 && wr_req;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_im, r_out_re, r_out_column};
    assign m_axis_tuser  = r_out_sat;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_valid && !adv2) |=> (r2_valid && $stable(r2_addr) && $stable(r2_ctrl)))
        else $error("update stage changed while stalled");

    a_fwd_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_wr_valid && r_wr_addr == $past(r2_addr) && r_wr_re == $past(n_res_re)))
        else $error("forwarding register missed a write");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv2 && r2_valid && !r2_ctrl.in_range)
            |=> (m_axis_tdata[M_TDATA_W-1:COL_W] == '0 && !m_axis_tuser))
        else $error("out-of-range column gave nonzero result");
`endif

endmodule
